// ===== hw/rtl/pmt_pkg.sv =====
// Shared types and constants for the periodic multi-timer.
package pmt_pkg;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   localparam int MS_W         = 24;
   localparam int SUB_W        = 4;
   localparam int TICK_W       = 32;
   localparam int MAX_RESULTS  = 16;
   localparam int FOUND_W      = $clog2(MAX_RESULTS + 1);
   localparam int CMD_Q_DEPTH  = 2;
   localparam int RSP_Q_DEPTH  = 2;

   typedef struct packed {
      logic             operation;
      logic [SUB_W-1:0] subscriber;
      logic [MS_W-1:0]  interval_ms;
   } req_type;

   typedef struct packed {
      logic [SUB_W-1:0] fired_subscriber;
      logic             last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_SET,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [SUB_W-1:0] subscriber;
      logic [MS_W-1:0]  interval_ms;
   } cmd_type;

endpackage

// ===== hw/rtl/pmt_fifo.sv =====
// Small first-in first-out queue of fixed-width words.
module pmt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== hw/rtl/pmt_front.sv =====
// Request decode and command queue in front of the timer sequencer.
module pmt_front #(
   parameter int NUM_SUBSCRIBERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pmt_pkg::req_type  req_data,
   output logic              full,
   output logic              cmd_valid,
   output pmt_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);
   import pmt_pkg::*;

   cmd_type cmd_in;
   logic    keep;
   logic    q_empty;

   // Classify the word; a set on a slot beyond the table is accepted and dropped.
   always_comb begin
      cmd_in.subscriber  = req_data.subscriber;
      cmd_in.interval_ms = req_data.interval_ms;
      keep               = 1'b1;
      if (req_data.operation == OP_TICK) begin
         cmd_in.kind = CMD_TICK;
      end else begin
         cmd_in.kind = (req_data.interval_ms == '0) ? CMD_CLEAR : CMD_SET;
         keep        = (32'(req_data.subscriber) < NUM_SUBSCRIBERS);
      end
   end

   pmt_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_Q_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push && keep),
      .din   (cmd_in),
      .full  (full),
      .pop   (cmd_pop),
      .dout  (cmd),
      .empty (q_empty)
   );

   assign cmd_valid = !q_empty;

endmodule

// ===== hw/rtl/pmt_div.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module pmt_div #(
   parameter int DVD_W = 32,
   parameter int DVS_W = 19
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVS_W-1:0] remainder
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quot_ff, quot_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   assign trial = {rem_ff, quot_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // Subtract when no borrow, shift the quotient bit in from the right
         if (!diff[DVS_W]) begin
            rem_in  = diff[DVS_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DVS_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/pmt_back.sv =====
// Period table, tick counter and the slot-walking sequencer.
module pmt_back #(
   parameter int NUM_SUBSCRIBERS = 16,
   parameter int STEP_MS         = 40,
   parameter int STEPS_W         = 19
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  pmt_pkg::cmd_type          cmd,
   output logic                      cmd_pop,
   output logic                      rsp_push,
   output pmt_pkg::rsp_type          rsp,
   input  logic                      rsp_full,
   output logic                      div_start,
   output logic [pmt_pkg::TICK_W-1:0] div_dividend,
   output logic [STEPS_W-1:0]        div_divisor,
   input  logic                      div_done,
   input  logic [STEPS_W-1:0]        div_remainder
);
   import pmt_pkg::*;

   localparam int SLOT_W      = (NUM_SUBSCRIBERS > 1) ? $clog2(NUM_SUBSCRIBERS) : 1;
   localparam int PROD_W      = 2 * MS_W + 1;
   localparam int RECIP_SHIFT = MS_W + $clog2(STEP_MS);
   // ceil(2^RECIP_SHIFT / STEP_MS) gives an exact floor division for any 24-bit dividend
   localparam logic [MS_W:0] RECIP =
      (MS_W + 1)'(((64'd1 << RECIP_SHIFT) + 64'(STEP_MS) - 64'd1) / 64'(STEP_MS));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET_STEPS,
      ST_READ,
      ST_CHECK,
      ST_MOD,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    slot_idx_ff, slot_idx_in;
   logic [SLOT_W-1:0]    set_slot_ff, set_slot_in;
   logic [MS_W-1:0]      set_x_ff, set_x_in;
   logic [TICK_W-1:0]    tick_count_ff, tick_count_in;
   logic [SLOT_W-1:0]    pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [FOUND_W-1:0]   found_ff, found_in;
   logic [NUM_SUBSCRIBERS-1:0] valid_ff, valid_in;

   logic [STEPS_W-1:0]   period_steps_ff [NUM_SUBSCRIBERS];
   logic [STEPS_W-1:0]   rd_data_ff;
   logic                 rd_valid_ff;
   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   logic [STEPS_W-1:0]   wr_data;
   logic [SLOT_W-1:0]    cmd_slot;
   logic                 at_last_slot;
   logic [PROD_W-1:0]    set_prod;

   assign cmd_slot     = SLOT_W'(cmd.subscriber);
   assign at_last_slot = (slot_idx_ff == SLOT_W'(NUM_SUBSCRIBERS - 1));
   assign set_prod     = PROD_W'(set_x_ff) * PROD_W'(RECIP);

   always_comb begin
      state_in      = state_ff;
      slot_idx_in   = slot_idx_ff;
      set_slot_in   = set_slot_ff;
      set_x_in      = set_x_ff;
      tick_count_in = tick_count_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      found_in      = found_ff;
      valid_in      = valid_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp.fired_subscriber = SUB_W'(pend_ff);
      rsp.last      = 1'b0;
      div_start     = 1'b0;
      div_dividend  = tick_count_ff;
      div_divisor   = rd_data_ff;
      wr_en         = 1'b0;
      wr_addr       = set_slot_ff;
      wr_data       = STEPS_W'(set_prod >> RECIP_SHIFT) + STEPS_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_CLEAR: begin
                     valid_in[cmd_slot] = 1'b0;
                  end
                  CMD_SET: begin
                     // Round up: ceil(ms / step) is floor((ms - 1) / step) + 1
                     set_slot_in = cmd_slot;
                     set_x_in    = cmd.interval_ms - 1'b1;
                     state_in    = ST_SET_STEPS;
                  end
                  CMD_TICK: begin
                     slot_idx_in   = '0;
                     pend_valid_in = 1'b0;
                     found_in      = '0;
                     state_in      = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SET_STEPS: begin
            wr_en                 = 1'b1;
            valid_in[set_slot_ff] = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (found_ff == FOUND_W'(MAX_RESULTS)) begin
               state_in = ST_FLUSH;
            end else if (rd_valid_ff) begin
               div_start = 1'b1;
               state_in  = ST_MOD;
            end else if (at_last_slot) begin
               state_in = ST_FLUSH;
            end else begin
               slot_idx_in = slot_idx_ff + 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               if (div_remainder == '0) begin
                  state_in = ST_EMIT;
               end else if (at_last_slot) begin
                  state_in = ST_FLUSH;
               end else begin
                  slot_idx_in = slot_idx_ff + 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_EMIT: begin
            // Hold the newest hit back so the last one of the tick can be marked
            if (!(pend_valid_ff && rsp_full)) begin
               rsp_push      = pend_valid_ff;
               pend_in       = slot_idx_ff;
               pend_valid_in = 1'b1;
               found_in      = found_ff + 1'b1;
               if (at_last_slot) begin
                  state_in = ST_FLUSH;
               end else begin
                  slot_idx_in = slot_idx_ff + 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!(pend_valid_ff && rsp_full)) begin
               rsp_push      = pend_valid_ff;
               rsp.last      = 1'b1;
               pend_valid_in = 1'b0;
               tick_count_in = tick_count_ff + 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_idx_ff   <= '0;
         set_slot_ff   <= '0;
         set_x_ff      <= '0;
         tick_count_ff <= TICK_W'(1);
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         found_ff      <= '0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         slot_idx_ff   <= slot_idx_in;
         set_slot_ff   <= set_slot_in;
         set_x_ff      <= set_x_in;
         tick_count_ff <= tick_count_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         period_steps_ff[wr_addr] <= wr_data;
      end
      rd_data_ff  <= period_steps_ff[slot_idx_ff];
      rd_valid_ff <= valid_ff[slot_idx_ff];
   end

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result word pushed into a full queue");

   a_found_bound: assert property (@(posedge clock) disable iff (reset)
      found_ff <= FOUND_W'(MAX_RESULTS))
      else $error("more hits than results allowed per tick");

   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && state_in == ST_IDLE)
      |=> tick_count_ff == $past(tick_count_ff) + TICK_W'(1))
      else $error("tick count did not advance at end of tick");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("pending hit left over after tick");

endmodule

// ===== hw/rtl/periodic_multi_timer_top.sv =====
// Set: the command leaves the queue in ST_IDLE and the table is written from ST_SET_STEPS.
// Tick: each slot is read (ST_READ, ST_CHECK); an active slot also runs the 32-step serial
// modulo (ST_MOD) and, when it fires, ST_EMIT; the walk ends in ST_FLUSH.
// Words queue two deep on each side, so push and pop stall independently.
// Reset is synchronous: all slots become inactive at once and the tick count is 1.
module periodic_multi_timer_top #(
   parameter int NUM_SUBSCRIBERS = 16,
   parameter int STEP_MS         = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pmt_pkg::req_type req_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output pmt_pkg::rsp_type rsp_data
);
   import pmt_pkg::*;

   localparam int MAX_STEPS = ((1 << MS_W) - 1 + STEP_MS - 1) / STEP_MS;
   localparam int STEPS_W   = $clog2(MAX_STEPS + 1);

   cmd_type              cmd;
   logic                 cmd_valid;
   logic                 cmd_pop;
   rsp_type              rsp;
   logic                 rsp_push;
   logic                 rsp_full;
   logic                 div_start;
   logic [TICK_W-1:0]    div_dividend;
   logic [STEPS_W-1:0]   div_divisor;
   logic                 div_done;
   logic [STEPS_W-1:0]   div_remainder;

   pmt_front #(
      .NUM_SUBSCRIBERS (NUM_SUBSCRIBERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   pmt_div #(
      .DVD_W (TICK_W),
      .DVS_W (STEPS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_remainder)
   );

   pmt_back #(
      .NUM_SUBSCRIBERS (NUM_SUBSCRIBERS),
      .STEP_MS         (STEP_MS),
      .STEPS_W         (STEPS_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .rsp_push      (rsp_push),
      .rsp           (rsp),
      .rsp_full      (rsp_full),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_done      (div_done),
      .div_remainder (div_remainder)
   );

   pmt_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp),
      .full  (rsp_full),
      .pop   (pop),
      .dout  (rsp_data),
      .empty (empty)
   );

endmodule

// ===== tb/periodic_multi_timer_top_test.sv =====
// Self-checking testbench for the periodic multi-timer: a directed table, then random scenes.
module periodic_multi_timer_top_test;
   import pmt_pkg::*;

   localparam int NUM_SLOTS    = 16;
   localparam int STEP_MS      = 40;
   localparam int TOTAL_WORDS  = 470;
   localparam int HOLD_CYCLES  = 2500;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 700;
   localparam int MAX_REPORTS  = 40;

   typedef struct {
      req_type              word;
      bit                   typed;
      logic [NUM_SLOTS-1:0] fires;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    push;
   req_type req_data;
   logic    full;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   // timer state as the block should hold it
   logic [TICK_W-1:0] tick_count_model;
   logic [18:0]       slot_steps [NUM_SLOTS];
   rsp_type           firing_queue [$];
   rsp_type           expected_word;
   directed_row_type  directed_rows [$];

   int errors      = 0;
   int idle_cycles = 0;
   int words_sent  = 0;
   bit steady       = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;

   periodic_multi_timer_top #(
      .NUM_SUBSCRIBERS(NUM_SLOTS),
      .STEP_MS(STEP_MS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_data(req_data),
      .full(full),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (errors < MAX_REPORTS) $display("mismatch: %s", what);
      errors++;
   endtask

   // Apply one word to the timer state and return the mask of slots that fire.
   function automatic logic [NUM_SLOTS-1:0] timer_apply(input req_type word);
      logic [NUM_SLOTS-1:0] fires;
      fires = '0;
      if (word.operation == OP_SET) begin
         if (word.interval_ms == '0) begin
            slot_steps[word.subscriber] = '0;
         end else begin
            slot_steps[word.subscriber] =
               19'((32'(word.interval_ms) + STEP_MS - 1) / STEP_MS);
         end
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_steps[i] != '0 && (tick_count_model % 32'(slot_steps[i])) == '0)
               fires[i] = 1'b1;
         end
         tick_count_model = tick_count_model + 1'b1;
      end
      return fires;
   endfunction

   function automatic directed_row_type direct(input logic op, input int sub, input int ms,
                                               input bit typed, input logic [15:0] fires);
      directed_row_type r;
      r.word.operation   = op;
      r.word.subscriber  = SUB_W'(sub);
      r.word.interval_ms = MS_W'(ms);
      r.typed            = typed;
      r.fires            = fires;
      return r;
   endfunction

   function automatic req_type random_word();
      req_type w;
      w.operation   = logic'($urandom_range(1));
      w.subscriber  = SUB_W'($urandom_range(NUM_SLOTS - 1));
      w.interval_ms = MS_W'($urandom());
      return w;
   endfunction

   function automatic req_type tick_word();
      req_type w;
      w = random_word();
      w.operation = OP_TICK;
      return w;
   endfunction

   function automatic req_type set_word(input int sub, input logic [MS_W-1:0] ms);
      req_type w;
      w.operation   = OP_SET;
      w.subscriber  = SUB_W'(sub);
      w.interval_ms = ms;
      return w;
   endfunction

   // Mostly short periods so that slots fire often; now and then huge ones.
   function automatic logic [MS_W-1:0] period_pick();
      int r;
      r = $urandom_range(99);
      if (r < 45) return MS_W'($urandom_range(5 * STEP_MS, 1));
      if (r < 65) return MS_W'(STEP_MS * $urandom_range(8, 1) + $urandom_range(2) - 1);
      if (r < 75) return '0;
      if (r < 88) return MS_W'($urandom_range(2000, 5 * STEP_MS + 1));
      return MS_W'($urandom());
   endfunction

   // Offer one word, hold it until taken, then queue the firings it causes.
   task automatic send_word(input req_type word, input bit typed,
                            input logic [NUM_SLOTS-1:0] typed_fires);
      logic [NUM_SLOTS-1:0] fires;
      int                   top;
      rsp_type              r;
      while (!steady && $urandom_range(99) < 24) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (full);
      fires = timer_apply(word);
      if (typed) fires = typed_fires;
      top = -1;
      for (int i = 0; i < NUM_SLOTS; i++) if (fires[i]) top = i;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (fires[i]) begin
            r.fired_subscriber = SUB_W'(i);
            r.last             = (i == top);
            firing_queue.push_back(r);
         end
      end
      words_sent++;
      @(negedge clock);
   endtask

   // receiver: random pop, plus one long hold-off to back the block up
   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            pop <= steady || $urandom_range(99) >= 24;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (firing_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected word: slot %0d last %0b",
                                      rsp_data.fired_subscriber, rsp_data.last));
         end else begin
            expected_word = firing_queue.pop_front();
            if (rsp_data.fired_subscriber !== expected_word.fired_subscriber)
               report_mismatch($sformatf("slot %0d, expected %0d",
                                         rsp_data.fired_subscriber,
                                         expected_word.fired_subscriber));
            if (rsp_data.last !== expected_word.last)
               report_mismatch($sformatf("last %0b on slot %0d, expected %0b",
                                         rsp_data.last, expected_word.fired_subscriber,
                                         expected_word.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int scene;
      tick_count_model = 1;
      for (int i = 0; i < NUM_SLOTS; i++) slot_steps[i] = '0;
      reset    = 1'b1;
      push     = 1'b0;
      req_data = '0;

      // tick count starts at 1 and advances once per tick row
      directed_rows.push_back(direct(OP_TICK, 0, 0, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 15, 24'hFFFFFF, 1, 16'h0000));
      directed_rows.push_back(direct(OP_SET, 0, 1, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 1, 16'h0001));
      directed_rows.push_back(direct(OP_SET, 15, 40, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 1, 16'h8001));
      directed_rows.push_back(direct(OP_SET, 15, 41, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 9, 123, 1, 16'h0001));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 1, 16'h8001));
      directed_rows.push_back(direct(OP_SET, 0, 0, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 1, 16'h0000));
      directed_rows.push_back(direct(OP_SET, 7, 24'hFFFFFF, 1, 16'h0000));
      directed_rows.push_back(direct(OP_SET, 3, 80, 1, 16'h0000));
      directed_rows.push_back(direct(OP_SET, 3, 120, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 0, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 0, 16'h0000));
      directed_rows.push_back(direct(OP_SET, 5, 0, 1, 16'h0000));
      directed_rows.push_back(direct(OP_SET, 8, 39, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 0, 16'h0000));
      directed_rows.push_back(direct(OP_SET, 15, 0, 1, 16'h0000));
      directed_rows.push_back(direct(OP_SET, 8, 0, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 1, 16'h0000));
      directed_rows.push_back(direct(OP_TICK, 0, 0, 1, 16'h0008));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].fires);

      while (words_sent < TOTAL_WORDS) begin
         steady = (words_sent >= 200 && words_sent < 300);
         scene  = $urandom_range(99);
         if (scene < 15 || (!hold_request && words_sent >= 350)) begin
            // fill every slot with a short period so ticks fire in long runs
            for (int s = 0; s < NUM_SLOTS; s++)
               send_word(set_word(s, MS_W'($urandom_range(3 * STEP_MS, 1))), 1'b0, '0);
            hold_request = 1'b1;
            repeat ($urandom_range(8, 4)) send_word(tick_word(), 1'b0, '0);
         end else if (scene < 75) begin
            repeat ($urandom_range(3, 1))
               send_word(set_word($urandom_range(NUM_SLOTS - 1), period_pick()), 1'b0, '0);
            repeat ($urandom_range(6, 2)) send_word(tick_word(), 1'b0, '0);
         end else if (scene < 85) begin
            repeat ($urandom_range(4, 1)) send_word(random_word(), 1'b0, '0);
         end else begin
            repeat ($urandom_range(4, 1))
               send_word(set_word($urandom_range(NUM_SLOTS - 1), '0), 1'b0, '0);
            repeat ($urandom_range(3, 1)) send_word(tick_word(), 1'b0, '0);
         end
      end
      steady = 1'b0;
      push <= 1'b0;

      while (firing_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && firing_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
